>>> rtl/pcc_pkg.sv
// Package with item types, controller and datapath link types, and the CRC byte step.
`timescale 1ns / 1ps

package pcc_pkg;

  localparam logic [31:0] CRC_POLY = 32'h04c11db7;

  // One input item
  typedef struct packed {
    logic       has_byte;
    logic [7:0] byte_value;
    logic       last;
  } item_t;

  // One result item
  typedef struct packed {
    logic [31:0] crc_value;
    logic [63:0] total_bytes;
  } result_t;

  // Controller states
  typedef enum logic {
    S_IDLE,
    S_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic take;
    logic feed;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic rest_zero;
    logic out_free;
  } status_t;

  // Shift one byte into a non-reflected CRC-32, MSB first
  function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] v;
    v = crc ^ {b, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      v = v[31] ? ((v << 1) ^ CRC_POLY) : (v << 1);
    end
    return v;
  endfunction

endpackage

>>> rtl/pcc_ctrl.sv
// Controller state machine: takes items, then sequences the length bytes and the result.
`timescale 1ns / 1ps

module pcc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_last,
  output logic             item_ready,
  input  pcc_pkg::status_t status,
  output pcc_pkg::cmd_t    cmd
);
  import pcc_pkg::*;

  state_t state;
  state_t state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid && item_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.rest_zero && status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    item_ready = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        cmd.take   = item_valid;
      end
      S_FINISH: begin
        cmd.feed = !status.rest_zero;
        cmd.emit = status.rest_zero && status.out_free;
      end
      default: begin
        item_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/pcc_datapath.sv
// Datapath: CRC and byte count registers, length shifter and result register.
`timescale 1ns / 1ps

module pcc_datapath (
  input  logic             clk,
  input  logic             rst,
  input  pcc_pkg::item_t   item,
  input  pcc_pkg::cmd_t    cmd,
  output pcc_pkg::status_t status,
  output logic             result_valid,
  input  logic             result_ready,
  output pcc_pkg::result_t result
);
  import pcc_pkg::*;

  logic [31:0] crc_reg;
  logic [63:0] byte_counter;
  logic [63:0] rest;
  logic [63:0] count_inc;

  assign count_inc = byte_counter + {63'd0, item.has_byte};

  assign status.rest_zero = (rest == 64'd0);
  assign status.out_free  = !result_valid || result_ready;

  // Absorb message bytes, then length bytes; clear on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg      <= '0;
      byte_counter <= '0;
      rest         <= '0;
    end else if (cmd.take) begin
      if (item.has_byte) begin
        crc_reg <= crc_feed(crc_reg, item.byte_value);
      end
      byte_counter <= count_inc;
      if (item.last) begin
        rest <= count_inc;
      end
    end else if (cmd.feed) begin
      crc_reg <= crc_feed(crc_reg, rest[7:0]);
      rest    <= rest >> 8;
    end else if (cmd.emit) begin
      crc_reg      <= '0;
      byte_counter <= '0;
    end
  end

  // Hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.crc_value   <= ~crc_reg;
      result.total_bytes <= byte_counter;
    end
  end

endmodule

>>> rtl/posix_cksum_crc32_top.sv
// Top level of the POSIX cksum CRC-32 engine: controller, datapath and checks.
`timescale 1ns / 1ps
//
//  channel   signals                                  direction  payload
//  item      item_valid, item_ready, item            in         item_t (has_byte, byte_value, last)
//  result    result_valid, result_ready, result      out        result_t (crc_value, total_bytes)
//
//  Message bytes and idle items are taken back to back.
//  After an item with last set, the N significant length bytes are shifted in
//  (0 to 8, set by the byte count), then the result is emitted.
//  The emit cycle waits while the result register still holds an untaken item.
//  Synchronous reset clears the CRC, the count, the controller and result valid.
//  item_ready is low from a last item until its result is loaded.

module posix_cksum_crc32_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  pcc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output pcc_pkg::result_t result
);
  import pcc_pkg::*;

  cmd_t    cmd;
  status_t status;

  pcc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_last  (item.last),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  pcc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // A last item stops intake until the result is loaded
  a_last_blocks: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.last) |=> !item_ready)
    else $error("item taken right after a last item");

  // A new result goes out only together with the return to intake
  a_emit_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> item_ready)
    else $error("result loaded without returning to idle");

  // Length feed never runs while items are taken
  a_feed_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.take && (cmd.feed || cmd.emit)))
    else $error("item taken during finish");

endmodule

>>> tb/cksum_crc_compare.sv
// Predicts cksum results from accepted items and compares them with the block's results.
`timescale 1ns / 1ps

module cksum_crc_compare (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_ready,
  input  pcc_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_ready,
  input  pcc_pkg::result_t result,
  output int               fail_count,
  output int               sums_due
);

  // Running CRC and byte count of the message in flight
  logic [31:0] msg_crc;
  logic [63:0] msg_len;

  // Results owed by the block, oldest first
  pcc_pkg::result_t due_sums[$];

  // Shift one byte into the CRC, MSB first, feedback taken bit by bit
  function automatic logic [31:0] crc_absorb_byte(input logic [31:0] c, input logic [7:0] d);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[31] ^ d[i];
      c = {c[30:0], 1'b0};
      if (fb) c = c ^ pcc_pkg::CRC_POLY;
    end
    return c;
  endfunction

  // Append the length bytes, low byte first, and complement
  function automatic pcc_pkg::result_t close_message(input logic [31:0] c,
                                                     input logic [63:0] n);
    pcc_pkg::result_t r;
    logic [63:0] rest;
    rest = n;
    while (rest != 64'd0) begin
      c = crc_absorb_byte(c, rest[7:0]);
      rest = rest >> 8;
    end
    r.crc_value = ~c;
    r.total_bytes = n;
    return r;
  endfunction

  always @(posedge clk) begin
    pcc_pkg::result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      msg_crc <= '0;
      msg_len <= '0;
      due_sums.delete();
      sums_due <= 0;
      fail_count <= 0;
    end else begin
      // Compare a delivered result with the oldest one owed
      if (result_valid && result_ready) begin
        if (due_sums.size() == 0) begin
          $error("result with none expected: crc_value %h, total_bytes %0d",
                 result.crc_value, result.total_bytes);
          errs++;
        end else begin
          want = due_sums.pop_front();
          if (result.crc_value !== want.crc_value) begin
            $error("crc_value: expected %h, got %h", want.crc_value, result.crc_value);
            errs++;
          end
          if (result.total_bytes !== want.total_bytes) begin
            $error("total_bytes: expected %0d, got %0d", want.total_bytes,
                   result.total_bytes);
            errs++;
          end
        end
      end
      if (errs != 0) begin
        fail_count <= fail_count + errs;
      end
      // Advance the predictor on an accepted item
      if (item_valid && item_ready) begin
        logic [31:0] c;
        logic [63:0] n;
        c = msg_crc;
        n = msg_len;
        if (item.has_byte) begin
          c = crc_absorb_byte(c, item.byte_value);
          n = n + 64'd1;
        end
        if (item.last) begin
          due_sums.push_back(close_message(c, n));
          c = '0;
          n = '0;
        end
        msg_crc <= c;
        msg_len <= n;
      end
      sums_due <= due_sums.size();
    end
  end

endmodule

>>> tb/posix_cksum_crc32_top_tb.sv
// Stimulus, handshake pacing and verdict for the cksum CRC-32 engine.
`timescale 1ns / 1ps

module posix_cksum_crc32_top_tb;

  localparam int ITEM_TARGET = 1450;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  pcc_pkg::item_t   item_bus = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  pcc_pkg::result_t result_bus;

  int  mismatches;
  int  outstanding;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  bit  calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  posix_cksum_crc32_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_bus),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_bus)
  );

  cksum_crc_compare sums (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_bus),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_bus),
    .fail_count   (mismatches),
    .sums_due     (outstanding)
  );

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("** posix_cksum_crc32_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stall the result side by a random count before each result
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  function automatic pcc_pkg::item_t mk(input logic hb, input logic [7:0] b, input logic l);
    pcc_pkg::item_t it;
    it.has_byte = hb;
    it.byte_value = b;
    it.last = l;
    return it;
  endfunction

  // Wait a random gap, then hold the item until it is accepted
  task automatic push_item(input pcc_pkg::item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item_bus <= it;
    do @(posedge clk); while (!item_ready);
    if (it.has_byte || it.last) items_sent++;
  endtask

  // Hold off until every owed result has come, then let the block settle
  task automatic drain();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One message of random bytes, with idle items mixed in
  task automatic send_random_message();
    int  len;
    bit  marker_end;
    if ($urandom_range(0, 59) == 0) len = $urandom_range(256, 400);
    else len = $urandom_range(0, 24);
    marker_end = (len == 0) || ($urandom_range(0, 2) == 0);
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 7) == 0) push_item(mk(1'b0, 8'($urandom), 1'b0));
      push_item(mk(1'b1, 8'($urandom), !marker_end && (k == len - 1)));
    end
    if (marker_end) push_item(mk(1'b0, 8'($urandom), 1'b1));
  endtask

  initial begin
    int    msg_count;
    string check_str;
    check_str = "123456789";
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty message: end marker alone, unused byte bits set
    push_item(mk(1'b0, 8'hFF, 1'b1));
    // Idle items change nothing, then a byte on the last item
    push_item(mk(1'b0, 8'hA5, 1'b0));
    push_item(mk(1'b1, 8'h00, 1'b0));
    push_item(mk(1'b0, 8'h5A, 1'b0));
    push_item(mk(1'b1, 8'hFF, 1'b1));
    // Single-byte messages at the byte extremes
    push_item(mk(1'b1, 8'h00, 1'b1));
    push_item(mk(1'b1, 8'hFF, 1'b1));
    push_item(mk(1'b1, 8'h80, 1'b1));
    // Check string, closed by an end marker
    foreach (check_str[i]) push_item(mk(1'b1, check_str[i], 1'b0));
    push_item(mk(1'b0, 8'h00, 1'b1));
    // Back-to-back empty messages
    push_item(mk(1'b0, 8'h00, 1'b1));
    push_item(mk(1'b0, 8'h7E, 1'b1));
    drain();

    // Random messages in phases, draining between some of them
    msg_count = 0;
    while (items_sent < ITEM_TARGET) begin
      if (msg_count % 16 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 1) == 0) drain();
      end
      send_random_message();
      msg_count++;
    end

    // Let the last results out, then give the verdict
    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("** posix_cksum_crc32_top: PASSED **");
    end else begin
      $display("** posix_cksum_crc32_top: FAILED **");
    end
    $finish;
  end

endmodule
